### src/fcpq_pkg.sv
// Package: widths, codes, entry and cell control types for the priority queue
package fcpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int NUMBER_W = 37;
    localparam int ITEMS_W  = 16;
    localparam int NAME_W   = 16;
    localparam int CLASS_W  = 2;
    localparam int STATUS_W = 2;
    localparam int WAIT_W   = 5;

    typedef logic [CLASS_W-1:0]  t_class;
    typedef logic [CLASS_W-1:0]  t_rank;
    typedef logic [NUMBER_W-1:0] t_number;
    typedef logic [ITEMS_W-1:0]  t_items;
    typedef logic [NAME_W-1:0]   t_name;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [WAIT_W-1:0]   t_wait;

    localparam logic    KIND_ADD   = 1'b0;
    localparam logic    KIND_SERVE = 1'b1;

    localparam t_status STATUS_DONE  = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    localparam t_class  CLASS_ORDINARY = 2'd0;
    localparam t_rank   RANK_LAST      = 2'd3;

    typedef struct packed {
        t_class  cls;
        t_number number;
        t_items  items;
        t_name   name;
    } t_entry;

    typedef struct packed {
        logic   add;
        logic   serve;
        t_rank  rank;
        t_entry entry;
    } t_cell_ctrl;

    typedef struct packed {
        t_status status;
        t_entry  served;
        t_wait   waiting;
    } t_result;

    // class 1 is served first, ordinary entries last
    function automatic t_rank rank_of(input t_class cls);
        t_rank r;
        if (cls == CLASS_ORDINARY) begin
            r = RANK_LAST;
        end else begin
            r = t_rank'(cls - t_class'(1));
        end
        return r;
    endfunction

endpackage

### src/fcpq_if.sv
// Interfaces: input and result channels of the priority queue
interface fcpq_in_if;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    fcpq_pkg::t_class        priority_class;
    fcpq_pkg::t_number       customer_number;
    fcpq_pkg::t_items        cart_items;
    fcpq_pkg::t_name         name_handle;

    modport source (
        output valid, kind, priority_class, customer_number, cart_items, name_handle,
        input  ready
    );
    modport sink (
        input  valid, kind, priority_class, customer_number, cart_items, name_handle,
        output ready
    );
endinterface

interface fcpq_out_if;
    logic                    valid;
    logic                    ready;
    fcpq_pkg::t_status       status;
    fcpq_pkg::t_class        served_class;
    fcpq_pkg::t_number       served_number;
    fcpq_pkg::t_items        served_items;
    fcpq_pkg::t_name         served_name;
    fcpq_pkg::t_wait         waiting_count;

    modport source (
        output valid, status, served_class, served_number, served_items, served_name,
               waiting_count,
        input  ready
    );
    modport sink (
        input  valid, status, served_class, served_number, served_items, served_name,
               waiting_count,
        output ready
    );
endinterface

### src/fcpq_cell.sv
// Cell: one queue slot that shifts toward the tail on insert and toward the head on serve
module fcpq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcpq_pkg::t_cell_ctrl  i_ctrl,
    input  fcpq_pkg::t_entry      i_prev_entry,
    input  logic                  i_prev_valid,
    input  logic                  i_prev_behind,
    input  fcpq_pkg::t_entry      i_next_entry,
    input  logic                  i_next_valid,
    output fcpq_pkg::t_entry      o_entry,
    output logic                  o_valid,
    output logic                  o_behind
);

    logic             r_valid;
    logic             n_valid;
    fcpq_pkg::t_entry r_entry;
    fcpq_pkg::t_entry n_entry;
    logic             behind;

    assign behind = r_valid && (fcpq_pkg::rank_of(r_entry.cls) <= i_ctrl.rank);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        priority if (i_ctrl.serve) begin
            n_valid = i_next_valid;
            n_entry = i_next_entry;
        end else if (i_ctrl.add && !behind) begin
            if (i_prev_behind) begin
                n_valid = 1'b1;
                n_entry = i_ctrl.entry;
            end else begin
                n_valid = i_prev_valid;
                n_entry = i_prev_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_entry  = r_entry;
    assign o_valid  = r_valid;
    assign o_behind = behind;

endmodule

### src/four_class_priority_queue_top.sv
// Top level: four-class strict priority queue built from a row of shifting cells
// Each result is registered in the next cycle; all cells insert or shift together.
// Throughput: one word per cycle when the last result is taken or none is held.
// The output register lets a new word enter while the last result is taken.
// Reset: synchronous, active low; clears cell valid bits, the fill count and output valid.
// Slot payloads are not reset.
module four_class_priority_queue_top #(
    parameter int QUEUE_DEPTH = fcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fcpq_in_if.sink           i_in,
    fcpq_out_if.source        o_out
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(QUEUE_DEPTH);

    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic                 r_out_valid;
    logic                 n_out_valid;
    fcpq_pkg::t_result    r_result;
    fcpq_pkg::t_result    n_result;

    fcpq_pkg::t_cell_ctrl ctrl;
    fcpq_pkg::t_entry     cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_behind;

    logic accept;
    logic full;
    logic empty;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_fill == FULL_LEVEL);
    assign empty      = (r_fill == '0);

    always_comb begin
        ctrl              = '0;
        ctrl.add          = accept && (i_in.kind == fcpq_pkg::KIND_ADD) && !full;
        ctrl.serve        = accept && (i_in.kind == fcpq_pkg::KIND_SERVE) && !empty;
        ctrl.rank         = fcpq_pkg::rank_of(i_in.priority_class);
        ctrl.entry.cls    = i_in.priority_class;
        ctrl.entry.number = i_in.customer_number;
        ctrl.entry.items  = i_in.cart_items;
        ctrl.entry.name   = i_in.name_handle;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        fcpq_pkg::t_entry prev_entry;
        logic             prev_valid;
        logic             prev_behind;
        fcpq_pkg::t_entry next_entry;
        logic             next_valid;

        if (g == 0) begin : g_head
            assign prev_entry  = '0;
            assign prev_valid  = 1'b0;
            assign prev_behind = 1'b1;
        end else begin : g_body
            assign prev_entry  = cell_entry[g-1];
            assign prev_valid  = cell_valid[g-1];
            assign prev_behind = cell_behind[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_entry = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_entry = cell_entry[g+1];
            assign next_valid = cell_valid[g+1];
        end

        fcpq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_prev_entry  (prev_entry),
            .i_prev_valid  (prev_valid),
            .i_prev_behind (prev_behind),
            .i_next_entry  (next_entry),
            .i_next_valid  (next_valid),
            .o_entry       (cell_entry[g]),
            .o_valid       (cell_valid[g]),
            .o_behind      (cell_behind[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        if (ctrl.add) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (ctrl.serve) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_result    = r_result;
        if (accept) begin
            n_out_valid      = 1'b1;
            n_result.status  = fcpq_pkg::STATUS_DONE;
            n_result.served  = '0;
            n_result.waiting = fcpq_pkg::t_wait'(n_fill);
            if (i_in.kind == fcpq_pkg::KIND_ADD) begin
                if (full) begin
                    n_result.status = fcpq_pkg::STATUS_FULL;
                end
            end else begin
                if (empty) begin
                    n_result.status = fcpq_pkg::STATUS_EMPTY;
                end else begin
                    n_result.served = cell_entry[0];
                end
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_result <= n_result;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_result.status;
    assign o_out.served_class  = r_result.served.cls;
    assign o_out.served_number = r_result.served.number;
    assign o_out.served_items  = r_result.served.items;
    assign o_out.served_name   = r_result.served.name;
    assign o_out.waiting_count = r_result.waiting;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_LEVEL)
        else $error("fill above depth");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == int'(r_fill))
        else $error("cell valid bits disagree with fill");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_valid[0] == !empty)
        else $error("head cell valid disagrees with fill");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.kind == fcpq_pkg::KIND_ADD) && full) |=>
            ($stable(r_fill) && (r_result.status == fcpq_pkg::STATUS_FULL)))
        else $error("add on full queue changed the queue");

endmodule
